/* rtl/raster_line_run_length_compressor_assert.svh */
// Assertion macros for the raster line run-length compressor
`ifndef RASTER_LINE_RUN_LENGTH_COMPRESSOR_ASSERT_SVH
`define RASTER_LINE_RUN_LENGTH_COMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlc assertion failed");
`define RLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlc assertion failed");
`else
`define RLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rlc_pkg.sv */
// Shared types and constants of the raster line run-length compressor
package rlc_pkg;

    localparam logic [1:0] MODE_RLE      = 2'd1;
    localparam logic [1:0] MODE_PACKBITS = 2'd2;

    localparam logic [8:0] REPEAT_LIMIT  = 9'd127;
    localparam logic [8:0] REPEAT_BASE   = 9'd257;
    localparam logic [7:0] LITERAL_HDR_0 = 8'h00;

    localparam int LEN_W     = 15;
    localparam int K_W       = 6;
    localparam int LIT_CNT_W = 7;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_REP,
        PH_LIT
    } phase_t;

    typedef enum logic [1:0] {
        FL_IDLE,
        FL_FETCH,
        FL_EMIT
    } flush_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte_a;
        logic [7:0]       out_byte_b;
        logic [7:0]       out_byte_c;
        logic [7:0]       out_byte_d;
        logic [2:0]       out_count;
        logic             line_done;
        logic [LEN_W-1:0] line_out_length;
    } out_item_t;

    // One accepted byte's work, handed from the coder to the emitter
    typedef struct packed {
        logic                 push;
        logic                 flush;
        logic [3:0][7:0]      bytes;
        logic [2:0]           count;
        logic                 last;
        logic [LEN_W-1:0]     total;
        logic [LIT_CNT_W-1:0] lit_count;
        logic [7:0]           lit_first;
    } job_t;

endpackage

/* rtl/rlc_ram.sv */
// Generic single-port-write, registered-read RAM
module rlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rlc_coder.sv */
// Coder: mode register, run state and per-byte compression decision
module rlc_coder #(
    parameter int MAX_LINE_BYTES = 8192,
    parameter int LITERAL_LIMIT  = 127,
    parameter int RLE_LIMIT      = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  logic              item_valid,
    input  logic              item_ready,
    input  rlc_pkg::in_item_t item,
    output rlc_pkg::job_t     job,
    output logic              mem_wr_en,
    output logic [((((LITERAL_LIMIT + 4) / 4) > 1) ? $clog2((LITERAL_LIMIT + 4) / 4) : 1) + 1:0]
                              mem_wr_pos,
    output logic [7:0]        mem_wr_data
);
    import rlc_pkg::*;

    localparam int ROWS    = (LITERAL_LIMIT + 4) / 4;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W   = ROW_W + 2;
    localparam int CAP_RAW = 2 * MAX_LINE_BYTES + 2;
    localparam int CAP_INT = (CAP_RAW > 32767) ? 32767 : CAP_RAW;
    localparam logic [15:0] CAP     = 16'(CAP_INT);
    localparam logic [8:0]  RLE_MAX = 9'(RLE_LIMIT);
    localparam logic [8:0]  LIT_MAX = 9'(LITERAL_LIMIT);

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic [7:0]      held;
        logic [8:0]      run;
        phase_t          phase;
        logic [7:0]      first;
    } step_t;

    logic [1:0]       mode_reg,  mode_next;
    logic [7:0]       held_reg,  held_next;
    logic [8:0]       run_reg,   run_next;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [7:0]       first_reg, first_next;

    logic                 accept;
    logic                 flush;
    logic                 lit_wr;
    logic [LIT_CNT_W-1:0] lit_n;
    logic [7:0]           olen;
    logic [15:0]          sum;
    logic [LEN_W-1:0]     total_new;
    step_t                res;

    function automatic step_t pb_start(input logic [7:0] x, input logic last, input step_t cur);
        step_t s;
        s       = cur;
        s.bytes = '0;
        s.cnt   = 3'd0;
        if (last)
        begin
            s.bytes[0] = LITERAL_HDR_0;
            s.bytes[1] = x;
            s.cnt      = 3'd2;
            s.phase    = PH_IDLE;
        end
        else
        begin
            s.held  = x;
            s.run   = 9'd1;
            s.phase = PH_ONE;
        end
        return s;
    endfunction

    function automatic step_t pb_one(input logic [7:0] x, input logic last, input step_t cur);
        step_t s;
        s       = cur;
        s.bytes = '0;
        s.cnt   = 3'd0;
        if (x == cur.held)
        begin
            if (last)
            begin
                s.bytes[0] = 8'(REPEAT_BASE - 9'd2);
                s.bytes[1] = x;
                s.cnt      = 3'd2;
                s.phase    = PH_IDLE;
            end
            else
            begin
                s.run   = 9'd2;
                s.phase = PH_REP;
            end
        end
        else if (last)
        begin
            s.bytes[0] = LITERAL_HDR_0;
            s.bytes[1] = cur.held;
            s.bytes[2] = LITERAL_HDR_0;
            s.bytes[3] = x;
            s.cnt      = 3'd4;
            s.phase    = PH_IDLE;
        end
        else
        begin
            // first literal byte lives in a register, the rest in memory
            s.first = cur.held;
            s.run   = 9'd1;
            s.held  = x;
            s.phase = PH_LIT;
        end
        return s;
    endfunction

    assign accept = item_valid && item_ready;

    always_comb
    begin
        step_t cur;
        step_t t;
        logic [7:0] x;
        logic       last;

        x         = item.data_byte;
        last      = item.last_byte;
        cur.bytes = '0;
        cur.cnt   = 3'd0;
        cur.held  = held_reg;
        cur.run   = run_reg;
        cur.phase = phase_reg;
        cur.first = first_reg;
        res       = cur;
        t         = cur;
        flush     = 1'b0;
        lit_wr    = 1'b0;
        lit_n     = '0;

        unique case (mode_reg)
            MODE_RLE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    res.held  = x;
                    res.run   = 9'd1;
                    res.phase = PH_ONE;
                end
                else if (x == held_reg && run_reg < RLE_MAX)
                begin
                    res.run = run_reg + 9'd1;
                end
                else
                begin
                    res.bytes[0] = 8'(run_reg - 9'd1);
                    res.bytes[1] = held_reg;
                    res.cnt      = 3'd2;
                    res.held     = x;
                    res.run      = 9'd1;
                end
                if (last)
                begin
                    if (res.cnt == 3'd0)
                    begin
                        res.bytes[0] = 8'(res.run - 9'd1);
                        res.bytes[1] = res.held;
                        res.cnt      = 3'd2;
                    end
                    else
                    begin
                        res.bytes[2] = 8'(res.run - 9'd1);
                        res.bytes[3] = res.held;
                        res.cnt      = 3'd4;
                    end
                    res.phase = PH_IDLE;
                end
            end
            MODE_PACKBITS:
            begin
                unique case (phase_reg)
                    PH_ONE:
                    begin
                        res = pb_one(x, last, cur);
                    end
                    PH_REP:
                    begin
                        if (x == held_reg && run_reg < REPEAT_LIMIT)
                        begin
                            res.run = run_reg + 9'd1;
                            if (last)
                            begin
                                res.bytes[0] = 8'(REPEAT_BASE - res.run);
                                res.bytes[1] = x;
                                res.cnt      = 3'd2;
                                res.phase    = PH_IDLE;
                            end
                        end
                        else
                        begin
                            t         = pb_start(x, last, cur);
                            res       = t;
                            res.bytes = {t.bytes[1], t.bytes[0], held_reg,
                                         8'(REPEAT_BASE - run_reg)};
                            res.cnt   = t.cnt + 3'd2;
                        end
                    end
                    PH_LIT:
                    begin
                        if (x != held_reg && run_reg < LIT_MAX)
                        begin
                            lit_wr   = 1'b1;
                            res.run  = run_reg + 9'd1;
                            res.held = x;
                            if (last)
                            begin
                                flush        = 1'b1;
                                lit_n        = res.run[LIT_CNT_W-1:0];
                                res.bytes[0] = LITERAL_HDR_0;
                                res.bytes[1] = x;
                                res.cnt      = 3'd2;
                                res.phase    = PH_IDLE;
                            end
                        end
                        else
                        begin
                            flush = 1'b1;
                            lit_n = run_reg[LIT_CNT_W-1:0];
                            res   = pb_one(x, last, cur);
                        end
                    end
                    default:
                    begin
                        res = pb_start(x, last, cur);
                    end
                endcase
            end
            default:
            begin
                res.bytes[0] = x;
                res.cnt      = 3'd1;
            end
        endcase

        olen = flush ? (8'd1 + {1'b0, lit_n} + {5'd0, res.cnt}) : {5'd0, res.cnt};
        sum  = {1'b0, total_reg} + {8'd0, olen};
        total_new = (sum > CAP) ? CAP[LEN_W-1:0] : sum[LEN_W-1:0];

        job.push      = accept;
        job.flush     = flush;
        job.bytes     = res.bytes;
        job.count     = res.cnt;
        job.last      = last;
        job.total     = total_new;
        job.lit_count = lit_n;
        job.lit_first = first_reg;
    end

    assign mem_wr_en   = accept && lit_wr;
    assign mem_wr_pos  = POS_W'(run_reg + 9'd1);
    assign mem_wr_data = held_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        run_next   = run_reg;
        phase_next = phase_reg;
        total_next = total_reg;
        first_next = first_reg;
        if (cfg_valid)
        begin
            // a mode write abandons the line in progress
            mode_next  = cfg_data;
            held_next  = 8'd0;
            run_next   = 9'd0;
            phase_next = PH_IDLE;
            total_next = '0;
        end
        else if (accept)
        begin
            first_next = res.first;
            if (item.last_byte)
            begin
                held_next  = 8'd0;
                run_next   = 9'd0;
                phase_next = PH_IDLE;
                total_next = '0;
            end
            else
            begin
                held_next  = res.held;
                run_next   = res.run;
                phase_next = res.phase;
                total_next = total_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 2'd0;
            held_reg  <= 8'd0;
            run_reg   <= 9'd0;
            phase_reg <= PH_IDLE;
            total_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            run_reg   <= run_next;
            phase_reg <= phase_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

/* rtl/rlc_emitter.sv */
// Emitter: literal flush sequencer over the store and two-entry result queue
module rlc_emitter #(
    parameter int LITERAL_LIMIT = 127
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rlc_pkg::job_t      job,
    output logic               item_ready,
    output logic               rd_en,
    output logic [((((LITERAL_LIMIT + 4) / 4) > 1) ? $clog2((LITERAL_LIMIT + 4) / 4) : 1)-1:0]
                               rd_row,
    input  logic [3:0][7:0]    rd_data,
    output logic               result_valid,
    input  logic               result_ready,
    output rlc_pkg::out_item_t result
);
    import rlc_pkg::*;

    localparam int ROWS  = (LITERAL_LIMIT + 4) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    flush_state_t state_reg, state_next;
    logic [K_W-1:0] k_reg, k_next;

    logic [LIT_CNT_W-1:0] fl_n_reg;
    logic [7:0]           fl_first_reg;
    logic [3:0][7:0]      fl_tail_reg;
    logic [2:0]           fl_tail_cnt_reg;
    logic                 fl_last_reg;
    logic [LEN_W-1:0]     fl_total_reg;
    logic [7:0]           fl_t_reg;
    logic [K_W-1:0]       fl_last_k_reg;

    logic [7:0] start_t;
    logic [7:0] start_t_m1;
    logic       start;

    out_item_t  q_slot_reg [2];
    logic [1:0] q_cnt_reg;
    logic       q_head_reg;
    logic       q_tail;
    logic       deq;
    logic       can_enq;
    logic       flush_enq;
    logic       direct_enq;
    logic       enq;
    out_item_t  flush_item;
    out_item_t  direct_item;
    out_item_t  enq_item;

    assign start      = job.push && job.flush;
    assign start_t    = 8'd1 + {1'b0, job.lit_count} + {5'd0, job.count};
    assign start_t_m1 = start_t - 8'd1;

    assign result_valid = (q_cnt_reg != 2'd0);
    assign result       = q_slot_reg[q_head_reg];
    assign deq          = result_valid && result_ready;
    assign can_enq      = (q_cnt_reg != 2'd2) || deq;
    assign item_ready   = (state_reg == FL_IDLE) && (q_cnt_reg != 2'd2);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        rd_en      = 1'b0;
        rd_row     = k_reg[ROW_W-1:0];
        flush_enq  = 1'b0;
        unique case (state_reg)
            FL_IDLE:
            begin
                if (start)
                begin
                    state_next = FL_FETCH;
                    k_next     = '0;
                end
            end
            FL_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = FL_EMIT;
            end
            FL_EMIT:
            begin
                if (can_enq)
                begin
                    flush_enq = 1'b1;
                    if (k_reg == fl_last_k_reg)
                    begin
                        state_next = FL_IDLE;
                    end
                    else
                    begin
                        // advance and fetch the next row while this one goes out
                        k_next = k_reg + 1'b1;
                        rd_en  = 1'b1;
                        rd_row = k_next[ROW_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = FL_IDLE;
            end
        endcase
    end

    // Byte p of the flush: header, first literal, stored literals, then the tail
    always_comb
    begin
        logic [3:0][7:0] lane;
        logic [7:0]      p;
        logic [7:0]      off;
        logic [2:0]      cnt;
        logic            done;

        lane = '0;
        cnt  = 3'd0;
        for (int j = 0; j < 4; j++)
        begin
            p   = {k_reg, 2'(j)};
            off = p - {1'b0, fl_n_reg} - 8'd1;
            if (p == 8'd0)
            begin
                lane[j] = {1'b0, fl_n_reg} - 8'd1;
            end
            else if (p == 8'd1)
            begin
                lane[j] = fl_first_reg;
            end
            else if (p <= {1'b0, fl_n_reg})
            begin
                lane[j] = rd_data[j];
            end
            else if (off < {5'd0, fl_tail_cnt_reg})
            begin
                lane[j] = fl_tail_reg[off[1:0]];
            end
            if (p < fl_t_reg)
            begin
                cnt = cnt + 3'd1;
            end
        end
        done = fl_last_reg && (k_reg == fl_last_k_reg);
        flush_item.out_byte_a      = lane[0];
        flush_item.out_byte_b      = lane[1];
        flush_item.out_byte_c      = lane[2];
        flush_item.out_byte_d      = lane[3];
        flush_item.out_count       = cnt;
        flush_item.line_done       = done;
        flush_item.line_out_length = done ? fl_total_reg : '0;
    end

    always_comb
    begin
        direct_item.out_byte_a      = job.bytes[0];
        direct_item.out_byte_b      = job.bytes[1];
        direct_item.out_byte_c      = job.bytes[2];
        direct_item.out_byte_d      = job.bytes[3];
        direct_item.out_count       = job.count;
        direct_item.line_done       = job.last;
        direct_item.line_out_length = job.last ? job.total : '0;
    end

    assign direct_enq = job.push && !job.flush && ((job.count != 3'd0) || job.last);
    assign enq        = direct_enq || flush_enq;
    assign enq_item   = flush_enq ? flush_item : direct_item;
    assign q_tail     = q_head_reg ^ (q_cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FL_IDLE;
            k_reg      <= '0;
            q_cnt_reg  <= 2'd0;
            q_head_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            q_cnt_reg  <= q_cnt_reg + {1'b0, enq} - {1'b0, deq};
            q_head_reg <= q_head_reg ^ deq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_slot_reg[q_tail] <= enq_item;
        end
        if (start && (state_reg == FL_IDLE))
        begin
            fl_n_reg        <= job.lit_count;
            fl_first_reg    <= job.lit_first;
            fl_tail_reg     <= job.bytes;
            fl_tail_cnt_reg <= job.count;
            fl_last_reg     <= job.last;
            fl_total_reg    <= job.total;
            fl_t_reg        <= start_t;
            fl_last_k_reg   <= start_t_m1[7:2];
        end
    end

endmodule

/* rtl/raster_line_run_length_compressor.sv */
// Top level of the raster line run-length compressor
// A byte's result, if any, is registered in the result queue; a literal flush goes through FL_FETCH
// and FL_EMIT, then gives one four-byte result a cycle while the queue has room.
// Input takes one byte a cycle while the queue has room and no flush runs; a flush holds input
// until FL_EMIT has sent its last row, read one row a cycle from the four literal store banks.
// Reset clears mode, run state, line total, flush sequencer and queue; no store clearing.
`include "raster_line_run_length_compressor_assert.svh"
module raster_line_run_length_compressor #(
    parameter int MAX_LINE_BYTES = 8192,
    parameter int LITERAL_LIMIT  = 127,
    parameter int RLE_LIMIT      = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  rlc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output rlc_pkg::out_item_t result
);
    import rlc_pkg::*;

    localparam int ROWS  = (LITERAL_LIMIT + 4) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = ROW_W + 2;

    job_t             job;
    logic             mem_wr_en;
    logic [POS_W-1:0] mem_wr_pos;
    logic [7:0]       mem_wr_data;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [3:0][7:0]  rd_data;

    assign cfg_ready = 1'b1;

    rlc_coder #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .LITERAL_LIMIT  (LITERAL_LIMIT),
        .RLE_LIMIT      (RLE_LIMIT)
    ) u_coder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .job         (job),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_pos  (mem_wr_pos),
        .mem_wr_data (mem_wr_data)
    );

    // Literal store: one bank per byte lane, a row holds four flush positions
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        rlc_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk     (clk),
            .wr_en   (mem_wr_en && (mem_wr_pos[1:0] == 2'(b))),
            .wr_addr (mem_wr_pos[POS_W-1:2]),
            .wr_data (mem_wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_row),
            .rd_data (rd_data[b])
        );
    end

    rlc_emitter #(
        .LITERAL_LIMIT (LITERAL_LIMIT)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .item_ready   (item_ready),
        .rd_en        (rd_en),
        .rd_row       (rd_row),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `RLC_ASSERT_IMP(a_store_port_split, clk, rst_n, 1'b1, !(mem_wr_en && rd_en))
    `RLC_ASSERT_NXT(a_flush_fetches, clk, rst_n, job.push && job.flush, rd_en)
    `RLC_ASSERT_IMP(a_done_has_bytes, clk, rst_n, result_valid && result.line_done, result.out_count != 3'd0)
    `RLC_ASSERT_IMP(a_length_with_done, clk, rst_n, result_valid && !result.line_done, result.line_out_length == 15'd0)

endmodule

/* verif/raster_line_run_length_compressor_tb.sv */
// Self-checking testbench for the raster line run-length compressor
module raster_line_run_length_compressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlc_pkg::*;

    localparam int          MAX_BYTES   = 8192;
    localparam int          LIT_LIMIT   = 127;
    localparam int          RUN_LIMIT   = 256;
    localparam int unsigned LEN_CAP     = (2 * MAX_BYTES + 2 > 32767) ? 32767 : 2 * MAX_BYTES + 2;
    localparam logic [1:0]  MODE_PASS   = 2'd0;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam int          SETTLE      = 12;
    localparam int          HOLD_CYCLES = 300;
    localparam int          RAND_ITEMS  = 230;
    localparam int          REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        ROW_MODE,
        ROW_RUN,
        ROW_ALT
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        int         count;
        logic       ends_line;
        logic       typed_valid;
        out_item_t  typed;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_data;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;

    // predictor state
    logic [1:0]  cur_mode;
    logic [7:0]  lit_buf [128];
    logic [7:0]  held_val;
    int unsigned run_len;
    phase_t      coder_state;
    int unsigned line_total;
    logic [7:0]  coded [$];
    out_item_t   step_results [$];
    out_item_t   predicted_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned bytes_sent;
    int unsigned mode_writes;
    int unsigned lines_by_mode [4];
    stim_row_t   stim_rows [$];

    raster_line_run_length_compressor #(
        .MAX_LINE_BYTES (MAX_BYTES),
        .LITERAL_LIMIT  (LIT_LIMIT),
        .RLE_LIMIT      (RUN_LIMIT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void put(input int unsigned v);
        coded.push_back(v[7:0]);
    endfunction

    function automatic void clear_line();
        held_val    = 8'h00;
        run_len     = 0;
        coder_state = PH_IDLE;
        line_total  = 0;
    endfunction

    function automatic void open_run(input logic [7:0] x, input logic lst);
        if (lst)
        begin
            put(LITERAL_HDR_0);
            put(x);
            coder_state = PH_IDLE;
        end
        else
        begin
            held_val    = x;
            run_len     = 1;
            coder_state = PH_ONE;
        end
    endfunction

    function automatic void pair_up(input logic [7:0] x, input logic lst);
        if (x == held_val)
        begin
            if (lst)
            begin
                put(REPEAT_BASE - 2);
                put(x);
                coder_state = PH_IDLE;
            end
            else
            begin
                run_len     = 2;
                coder_state = PH_REP;
            end
        end
        else if (lst)
        begin
            put(LITERAL_HDR_0);
            put(held_val);
            put(LITERAL_HDR_0);
            put(x);
            coder_state = PH_IDLE;
        end
        else
        begin
            lit_buf[0]  = held_val;
            run_len     = 1;
            held_val    = x;
            coder_state = PH_LIT;
        end
    endfunction

    function automatic void flush_literals();
        put(run_len - 1);
        for (int unsigned i = 0; i < run_len && i < 128; i++)
            put(lit_buf[i]);
    endfunction

    // Work out the results that one accepted byte causes, into step_results
    function automatic void compress_byte(input logic [7:0] x, input logic lst);
        int unsigned nres;
        int unsigned pos;
        logic [7:0]  b4 [4];
        out_item_t   r;
        coded.delete();
        step_results.delete();
        if (cur_mode == MODE_RLE)
        begin
            if (coder_state == PH_IDLE)
            begin
                held_val    = x;
                run_len     = 1;
                coder_state = PH_ONE;
            end
            else if (x == held_val && run_len < RUN_LIMIT)
                run_len++;
            else
            begin
                put(run_len - 1);
                put(held_val);
                held_val = x;
                run_len  = 1;
            end
            if (lst)
            begin
                put(run_len - 1);
                put(held_val);
                coder_state = PH_IDLE;
            end
        end
        else if (cur_mode == MODE_PACKBITS)
        begin
            case (coder_state)
                PH_ONE:
                    pair_up(x, lst);
                PH_REP:
                    if (x == held_val && run_len < REPEAT_LIMIT)
                    begin
                        run_len++;
                        if (lst)
                        begin
                            put(REPEAT_BASE - run_len);
                            put(x);
                            coder_state = PH_IDLE;
                        end
                    end
                    else
                    begin
                        put(REPEAT_BASE - run_len);
                        put(held_val);
                        open_run(x, lst);
                    end
                PH_LIT:
                    if (x != held_val && run_len < LIT_LIMIT)
                    begin
                        lit_buf[run_len % 128] = held_val;
                        run_len++;
                        held_val = x;
                        // the final byte is never folded into the literal run
                        if (lst)
                        begin
                            flush_literals();
                            put(LITERAL_HDR_0);
                            put(x);
                            coder_state = PH_IDLE;
                        end
                    end
                    else
                    begin
                        flush_literals();
                        pair_up(x, lst);
                    end
                default:
                    open_run(x, lst);
            endcase
        end
        else
            put(x);

        line_total += coded.size();
        if (line_total > LEN_CAP)
            line_total = LEN_CAP;

        nres = (coded.size() + 3) / 4;
        if (nres == 0 && lst)
            nres = 1;
        for (int unsigned k = 0; k < nres; k++)
        begin
            r = '0;
            for (int unsigned j = 0; j < 4; j++)
            begin
                pos   = k * 4 + j;
                b4[j] = (pos < coded.size()) ? coded[pos] : 8'h00;
                if (pos < coded.size())
                    r.out_count++;
            end
            r.out_byte_a = b4[0];
            r.out_byte_b = b4[1];
            r.out_byte_c = b4[2];
            r.out_byte_d = b4[3];
            r.line_done  = lst && (k + 1 == nres);
            r.line_out_length = r.line_done ? line_total[LEN_W-1:0] : '0;
            step_results.push_back(r);
        end

        if (lst)
        begin
            lines_by_mode[cur_mode]++;
            clear_line();
        end
    endfunction

    function automatic out_item_t result_of(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d,
                                            input logic [2:0] n, input logic done,
                                            input int unsigned len);
        out_item_t r;
        r.out_byte_a      = a;
        r.out_byte_b      = b;
        r.out_byte_c      = c;
        r.out_byte_d      = d;
        r.out_count       = n;
        r.line_done       = done;
        r.line_out_length = len[LEN_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] value,
                                    input int count, input logic ends_line,
                                    input logic typed_valid, input out_item_t typed);
        stim_row_t row;
        row.kind        = kind;
        row.value       = value;
        row.count       = count;
        row.ends_line   = ends_line;
        row.typed_valid = typed_valid;
        row.typed       = typed;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [1:0] pick_mode();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return MODE_PASS;
        if (roll == 1)
            return MODE_SPARE;
        return (roll < 6) ? MODE_RLE : MODE_PACKBITS;
    endfunction

    // Offer one byte; entered just after a rising edge, returns at the accepting edge
    task automatic push_byte(input logic [7:0] b, input logic lst,
                             input logic typed_valid, input out_item_t typed);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{data_byte: b, last_byte: lst};
        do @(posedge clk); while (!item_ready);
        bytes_sent++;
        compress_byte(b, lst);
        if (typed_valid)
            predicted_results.push_back(typed);
        else
            foreach (step_results[i])
                predicted_results.push_back(step_results[i]);
    endtask

    // Drop valid and let every outstanding result drain, then give a flush time to finish
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (predicted_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cur_mode = m;
        clear_line();
        mode_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_line(output int unsigned sent);
        int unsigned len;
        int unsigned run;
        int unsigned i;
        logic [7:0]  val;
        logic        broken;
        len    = ($urandom_range(11) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 16);
        broken = ($urandom_range(9) == 0);
        i      = 0;
        while (i < len)
        begin
            if (len > 40)
                run = ($urandom_range(7) == 0) ? $urandom_range(2, 4) : 1;
            else
                run = ($urandom_range(2) == 0) ? 1 : $urandom_range(2, 6);
            // a narrow alphabet now and then, so that neighbours collide
            val = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
            for (int unsigned k = 0; k < run && i < len; k++)
            begin
                push_byte(val, !broken && (i == len - 1), 1'b0, '0);
                i++;
            end
        end
        // abandon the line part-way through
        if (broken)
            write_mode(pick_mode());
        sent = len;
    endtask

    initial
    begin
        int unsigned held;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                result_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: a=%h b=%h c=%h d=%h n=%0d done=%b len=%0d",
                             result.out_byte_a, result.out_byte_b, result.out_byte_c,
                             result.out_byte_d, result.out_count, result.line_done,
                             result.line_out_length);
            end
            else
            begin
                want = predicted_results.pop_front();
                results_checked++;
                if (result.out_byte_a !== want.out_byte_a ||
                    result.out_byte_b !== want.out_byte_b ||
                    result.out_byte_c !== want.out_byte_c ||
                    result.out_byte_d !== want.out_byte_d ||
                    result.out_count !== want.out_count ||
                    result.line_done !== want.line_done ||
                    result.line_out_length !== want.line_out_length)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp a=%h b=%h c=%h d=%h n=%0d done=%b len=%0d | got a=%h b=%h c=%h d=%h n=%0d done=%b len=%0d",
                                 want.out_byte_a, want.out_byte_b, want.out_byte_c,
                                 want.out_byte_d, want.out_count, want.line_done,
                                 want.line_out_length, result.out_byte_a, result.out_byte_b,
                                 result.out_byte_c, result.out_byte_d, result.out_count,
                                 result.line_done, result.line_out_length);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase_items;
        logic [7:0]  b;
        logic        fin;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = MODE_PASS;
        item_valid    = 1'b0;
        item          = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 64;
        mismatches    = 0;
        results_checked = 0;
        bytes_sent    = 0;
        mode_writes   = 0;
        foreach (lines_by_mode[i])
            lines_by_mode[i] = 0;
        cur_mode = MODE_PASS;
        clear_line();

        // straight after reset the block passes bytes through
        add_row(ROW_RUN, 8'h00, 1, 1'b0, 1'b1, result_of(8'h00, 0, 0, 0, 1, 0, 0));
        add_row(ROW_RUN, 8'hFF, 1, 1'b1, 1'b1, result_of(8'hFF, 0, 0, 0, 1, 1, 2));
        add_row(ROW_MODE, MODE_SPARE, 0, 1'b0, 1'b0, '0);
        add_row(ROW_RUN, 8'hA5, 1, 1'b1, 1'b1, result_of(8'hA5, 0, 0, 0, 1, 1, 1));
        add_row(ROW_MODE, MODE_RLE, 0, 1'b0, 1'b0, '0);
        add_row(ROW_RUN, 8'h5A, 3, 1'b1, 1'b1, result_of(8'h02, 8'h5A, 0, 0, 2, 1, 2));
        add_row(ROW_RUN, 8'h00, 256, 1'b1, 1'b1, result_of(8'hFF, 8'h00, 0, 0, 2, 1, 2));
        add_row(ROW_RUN, 8'hFF, 257, 1'b1, 1'b1,
                result_of(8'hFF, 8'hFF, 8'h00, 8'hFF, 4, 1, 4));
        add_row(ROW_ALT, 8'h0F, 6, 1'b1, 1'b0, '0);
        add_row(ROW_MODE, MODE_PACKBITS, 0, 1'b0, 1'b0, '0);
        add_row(ROW_RUN, 8'h11, 1, 1'b1, 1'b1, result_of(8'h00, 8'h11, 0, 0, 2, 1, 2));
        add_row(ROW_RUN, 8'h22, 2, 1'b1, 1'b1, result_of(8'hFF, 8'h22, 0, 0, 2, 1, 2));
        add_row(ROW_RUN, 8'h33, 127, 1'b1, 1'b1, result_of(8'h82, 8'h33, 0, 0, 2, 1, 2));
        add_row(ROW_RUN, 8'h44, 128, 1'b1, 1'b1,
                result_of(8'h82, 8'h44, 8'h00, 8'h44, 4, 1, 4));
        add_row(ROW_ALT, 8'h12, 2, 1'b1, 1'b1,
                result_of(8'h00, 8'h12, 8'h00, 8'hED, 4, 1, 4));
        add_row(ROW_ALT, 8'h3C, 3, 1'b1, 1'b0, '0);
        add_row(ROW_ALT, 8'h55, 130, 1'b1, 1'b0, '0);
        // a mode write in the middle of a line drops what is held
        add_row(ROW_RUN, 8'h66, 5, 1'b0, 1'b0, '0);
        add_row(ROW_MODE, MODE_RLE, 0, 1'b0, 1'b0, '0);
        add_row(ROW_RUN, 8'h77, 1, 1'b1, 1'b1, result_of(8'h00, 8'h77, 0, 0, 2, 1, 2));
        // overlong line: the total saturates
        add_row(ROW_ALT, 8'h81, 8200, 1'b1, 1'b1,
                result_of(8'h00, 8'h81, 8'h00, 8'h7E, 4, 1, LEN_CAP));
        add_row(ROW_MODE, MODE_PASS, 0, 1'b0, 1'b0, '0);
        add_row(ROW_ALT, 8'hC3, 9, 1'b1, 1'b0, '0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_MODE)
                write_mode(stim_rows[r].value[1:0]);
            else
                for (int n = 0; n < stim_rows[r].count; n++)
                begin
                    b   = (stim_rows[r].kind == ROW_ALT && n % 2 == 1) ?
                          ~stim_rows[r].value : stim_rows[r].value;
                    fin = (n == stim_rows[r].count - 1);
                    push_byte(b, fin && stim_rows[r].ends_line,
                              fin && stim_rows[r].typed_valid, stim_rows[r].typed);
                end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 33 : 0;
            write_mode(pick_mode());
            // stall the output while input keeps coming
            if (ph == 2)
                hold_off_req = 1'b1;
            phase_items = 0;
            while (phase_items < RAND_ITEMS / 3)
            begin
                if ($urandom_range(5) == 0)
                    write_mode(pick_mode());
                send_random_line(sent);
                phase_items += sent;
            end
        end

        wait_idle();

        $display("covered %0d bytes in lines of pass-through %0d, run-length %0d, packbits %0d, spare code %0d, with %0d mode writes",
                 bytes_sent, lines_by_mode[MODE_PASS], lines_by_mode[MODE_RLE],
                 lines_by_mode[MODE_PACKBITS], lines_by_mode[MODE_SPARE], mode_writes);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/rlc_pkg.sv
rtl/rlc_ram.sv
rtl/rlc_coder.sv
rtl/rlc_emitter.sv
rtl/raster_line_run_length_compressor.sv
verif/raster_line_run_length_compressor_tb.sv
